### design/tree_lca_distance_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tree LCA distance block
// Shared concurrent assertion forms, one use per line in the design files.
// ----------------------------------------------------------------------------
`ifndef TREE_LCA_DISTANCE_DEFINES_SVH
`define TREE_LCA_DISTANCE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define TLD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define TLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// Widths, codes, beat structures, sequencer states and small arithmetic
// helpers shared by the tree LCA distance block.
// ----------------------------------------------------------------------------
package tld_pkg;

   localparam int FIELD_W        = 12;
   localparam int ACTION_W       = 2;
   localparam int DIST_W         = 13;
   localparam int DEPTH_W        = 12;
   localparam int SUM_W          = 17;
   localparam int SHIFT_W        = 4;
   localparam int MAX_NODES_DEF  = 4096;
   localparam int LOG_LEVELS_DEF = 12;

   localparam logic [DEPTH_W-1:0]  DEPTH_MAX        = 12'd4095;
   localparam logic [FIELD_W-1:0]  NODE_COUNT_RESET = 12'd4095;

   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BUILD = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [FIELD_W-1:0]  node_a;
      logic [FIELD_W-1:0]  node_b;
   } req_beat_type;

   typedef struct packed {
      logic [ACTION_W-1:0] kind;
      logic [FIELD_W-1:0]  ancestor;
      logic [DIST_W-1:0]   distance;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BLD_RD1,
      S_BLD_RD2,
      S_BLD_WR,
      S_DEP_START,
      S_DEP_WALK,
      S_QRY_DA,
      S_QRY_DB,
      S_LIFT_TEST,
      S_LIFT_ANC,
      S_LIFT_DEP,
      S_PAIR_CHECK,
      S_PAIR_WALK,
      S_QRY_FINAL,
      S_QRY_DC,
      S_DONE
   } seq_state_type;

   // Depth plus a power of two, saturating at the depth ceiling.
   function automatic logic [DEPTH_W-1:0] depth_add(input logic [DEPTH_W-1:0] d,
                                                    input logic [SHIFT_W-1:0] sh);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(d) + (SUM_W'(1) << sh);
      return (sum > SUM_W'(DEPTH_MAX)) ? DEPTH_MAX : sum[DEPTH_W-1:0];
   endfunction

   // True when node a sits at least 2^sh levels below node b.
   function automatic logic lift_ok(input logic [DEPTH_W-1:0] da,
                                    input logic [DEPTH_W-1:0] db,
                                    input logic [SHIFT_W-1:0] sh);
      logic [SUM_W-1:0] reach;
      reach = SUM_W'(db) + (SUM_W'(1) << sh);
      return SUM_W'(da) >= reach;
   endfunction

endpackage

### design/tld_ifs.sv
// ----------------------------------------------------------------------------
// tld channel interfaces
// Valid/ready channels for requests, responses and the node count register.
// ----------------------------------------------------------------------------
interface tld_req_if import tld_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [FIELD_W-1:0]  node_a;
   logic [FIELD_W-1:0]  node_b;

   modport source (output valid, action, node_a, node_b, input ready);
   modport sink   (input valid, action, node_a, node_b, output ready);
endinterface

interface tld_rsp_if import tld_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] kind;
   logic [FIELD_W-1:0]  ancestor;
   logic [DIST_W-1:0]   distance;

   modport source (output valid, kind, ancestor, distance, input ready);
   modport sink   (input valid, kind, ancestor, distance, output ready);
endinterface

interface tld_csr_if import tld_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### design/tld_anc_mem.sv
// ----------------------------------------------------------------------------
// tld_anc_mem
// Ancestor table: one write port, two registered read ports. Entries are
// addressed by node and level; node 0 always reads back as 0.
// ----------------------------------------------------------------------------
module tld_anc_mem #(
   parameter int NODE_W,
   parameter int LVL_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [NODE_W-1:0] wr_node,
   input  logic [LVL_W-1:0]  wr_level,
   input  logic [NODE_W-1:0] wr_data,
   input  logic [NODE_W-1:0] rd0_node,
   input  logic [LVL_W-1:0]  rd0_level,
   output logic [NODE_W-1:0] rd0_data,
   input  logic [NODE_W-1:0] rd1_node,
   input  logic [LVL_W-1:0]  rd1_level,
   output logic [NODE_W-1:0] rd1_data
);

   localparam int ADDR_W = NODE_W + LVL_W;

   logic [NODE_W-1:0] mem [2**ADDR_W];
   logic [NODE_W-1:0] rd0_raw_ff;
   logic [NODE_W-1:0] rd1_raw_ff;
   logic              rd0_zero_ff;
   logic              rd1_zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_node, wr_level}] <= wr_data;
      end
      rd0_raw_ff  <= mem[{rd0_node, rd0_level}];
      rd1_raw_ff  <= mem[{rd1_node, rd1_level}];
      rd0_zero_ff <= (rd0_node == '0);
      rd1_zero_ff <= (rd1_node == '0);
   end

   // Node 0 is the sink: it is never written and all its ancestors are 0.
   assign rd0_data = rd0_zero_ff ? '0 : rd0_raw_ff;
   assign rd1_data = rd1_zero_ff ? '0 : rd1_raw_ff;

endmodule

### design/tld_depth_mem.sv
// ----------------------------------------------------------------------------
// tld_depth_mem
// Depth table: one write port, one registered read port. Node 0 reads as
// depth 0.
// ----------------------------------------------------------------------------
module tld_depth_mem import tld_pkg::*; #(
   parameter int NODE_W
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [NODE_W-1:0]  wr_node,
   input  logic [DEPTH_W-1:0] wr_data,
   input  logic [NODE_W-1:0]  rd_node,
   output logic [DEPTH_W-1:0] rd_data
);

   logic [DEPTH_W-1:0] mem [2**NODE_W];
   logic [DEPTH_W-1:0] rd_raw_ff;
   logic               rd_zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_node] <= wr_data;
      end
      rd_raw_ff  <= mem[rd_node];
      rd_zero_ff <= (rd_node == '0);
   end

   assign rd_data = rd_zero_ff ? '0 : rd_raw_ff;

endmodule

### design/tld_seq.sv
// ----------------------------------------------------------------------------
// tld_seq
// Sequencer for loads, the table build pass and LCA queries. Most steps are
// a read of one of the tables followed by use of the registered data.
// ----------------------------------------------------------------------------
`include "tree_lca_distance_defines.svh"

module tld_seq import tld_pkg::*; #(
   parameter int MAX_NODES,
   parameter int LOG_LEVELS,
   parameter int NODE_W,
   parameter int LVL_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_beat_type       req_beat,
   input  logic [FIELD_W-1:0] node_count,
   input  logic               rsp_free,
   output logic               done,
   output rsp_beat_type       result,
   output logic               anc_wr_en,
   output logic [NODE_W-1:0]  anc_wr_node,
   output logic [LVL_W-1:0]   anc_wr_level,
   output logic [NODE_W-1:0]  anc_wr_data,
   output logic [NODE_W-1:0]  anc_rd0_node,
   output logic [LVL_W-1:0]   anc_rd0_level,
   input  logic [NODE_W-1:0]  anc_rd0_data,
   output logic [NODE_W-1:0]  anc_rd1_node,
   output logic [LVL_W-1:0]   anc_rd1_level,
   input  logic [NODE_W-1:0]  anc_rd1_data,
   output logic               dep_wr_en,
   output logic [NODE_W-1:0]  dep_wr_node,
   output logic [DEPTH_W-1:0] dep_wr_data,
   output logic [NODE_W-1:0]  dep_rd_node,
   input  logic [DEPTH_W-1:0] dep_rd_data
);

   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LOG_LEVELS - 1);

   function automatic logic [NODE_W-1:0] to_node(input logic [FIELD_W-1:0] f);
      logic [NODE_W-1:0] n;
      n = '0;
      if (32'(f) < MAX_NODES) begin
         n = NODE_W'(f);
      end
      return n;
   endfunction

   seq_state_type      state_ff, state_in;
   logic [LVL_W-1:0]   k_ff, k_in;
   logic [NODE_W-1:0]  i_ff, i_in;
   logic [NODE_W-1:0]  top_ff, top_in;
   logic [NODE_W-1:0]  qa_ff, qa_in;
   logic [NODE_W-1:0]  qb_ff, qb_in;
   logic [DEPTH_W-1:0] da_ff, da_in;
   logic [DEPTH_W-1:0] db_ff, db_in;
   logic [DIST_W-1:0]  dsum_ff, dsum_in;
   rsp_beat_type       res_ff, res_in;

   logic               accept;
   logic [NODE_W-1:0]  a_idx;
   logic [NODE_W-1:0]  b_idx;
   logic [NODE_W-1:0]  top_calc;
   logic [LVL_W-1:0]   k_dec;
   logic               walk_hit;
   logic [NODE_W-1:0]  walk_node;
   logic [DEPTH_W-1:0] walk_depth;
   logic               pair_diff;
   logic [NODE_W-1:0]  pair_a;
   logic [NODE_W-1:0]  pair_b;
   logic               lift_go;
   logic [DIST_W-1:0]  twice_dc;

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign a_idx      = to_node(req_beat.node_a);
   assign b_idx      = to_node(req_beat.node_b);
   assign top_calc   = (32'(node_count) > MAX_NODES - 1) ? NODE_W'(MAX_NODES - 1)
                                                         : NODE_W'(node_count);
   assign k_dec      = k_ff - LVL_W'(1);
   assign walk_hit   = (anc_rd0_data != '0);
   assign walk_node  = walk_hit ? anc_rd0_data : qa_ff;
   assign walk_depth = walk_hit ? depth_add(da_ff, SHIFT_W'(k_ff)) : da_ff;
   assign pair_diff  = (anc_rd0_data != anc_rd1_data);
   assign pair_a     = pair_diff ? anc_rd0_data : qa_ff;
   assign pair_b     = pair_diff ? anc_rd1_data : qb_ff;
   assign lift_go    = lift_ok(da_ff, db_ff, SHIFT_W'(k_ff));
   assign twice_dc   = {dep_rd_data, 1'b0};
   assign result     = res_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_beat.action)
                  ACT_BUILD: state_in = (top_calc == '0) ? S_DONE : S_BLD_RD1;
                  ACT_QUERY: state_in = S_QRY_DA;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_BLD_RD1:   state_in = S_BLD_RD2;
         S_BLD_RD2:   state_in = S_BLD_WR;
         S_BLD_WR: begin
            state_in = ((i_ff == top_ff) && (k_ff == LVL_LAST)) ? S_DEP_START : S_BLD_RD1;
         end
         S_DEP_START: state_in = S_DEP_WALK;
         S_DEP_WALK: begin
            if (k_ff == '0) begin
               state_in = (i_ff == top_ff) ? S_DONE : S_DEP_START;
            end
         end
         S_QRY_DA:    state_in = S_QRY_DB;
         S_QRY_DB:    state_in = S_LIFT_TEST;
         S_LIFT_TEST: begin
            if (lift_go) begin
               state_in = S_LIFT_ANC;
            end else if (k_ff == '0) begin
               state_in = S_PAIR_CHECK;
            end
         end
         S_LIFT_ANC:  state_in = S_LIFT_DEP;
         S_LIFT_DEP:  state_in = (k_ff == '0) ? S_PAIR_CHECK : S_LIFT_TEST;
         S_PAIR_CHECK: state_in = (qa_ff == qb_ff) ? S_QRY_DC : S_PAIR_WALK;
         S_PAIR_WALK: begin
            if (k_ff == '0) begin
               state_in = S_QRY_FINAL;
            end
         end
         S_QRY_FINAL: state_in = S_QRY_DC;
         S_QRY_DC:    state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // Handshake and table port outputs.
   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      done          = 1'b0;
      anc_wr_en     = 1'b0;
      anc_wr_node   = i_ff;
      anc_wr_level  = k_ff;
      anc_wr_data   = anc_rd0_data;
      anc_rd0_node  = qa_ff;
      anc_rd0_level = k_ff;
      anc_rd1_node  = qb_ff;
      anc_rd1_level = k_ff;
      dep_wr_en     = 1'b0;
      dep_wr_node   = i_ff;
      dep_wr_data   = walk_depth;
      dep_rd_node   = qa_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_beat.action == ACT_LOAD) && (a_idx != '0)) begin
               anc_wr_en    = 1'b1;
               anc_wr_node  = a_idx;
               anc_wr_level = '0;
               anc_wr_data  = b_idx;
            end
            dep_rd_node = a_idx;
         end
         S_BLD_RD1: begin
            anc_rd0_node  = i_ff;
            anc_rd0_level = k_dec;
         end
         S_BLD_RD2: begin
            anc_rd0_node  = anc_rd0_data;
            anc_rd0_level = k_dec;
         end
         S_BLD_WR: begin
            anc_wr_en = 1'b1;
         end
         S_DEP_START: begin
            anc_rd0_node  = i_ff;
            anc_rd0_level = LVL_LAST;
         end
         S_DEP_WALK: begin
            if (k_ff == '0) begin
               dep_wr_en = 1'b1;
            end else begin
               anc_rd0_node  = walk_node;
               anc_rd0_level = k_dec;
            end
         end
         S_QRY_DA: begin
            dep_rd_node = qb_ff;
         end
         S_LIFT_ANC: begin
            dep_rd_node = anc_rd0_data;
         end
         S_PAIR_WALK: begin
            anc_rd0_node = pair_a;
            anc_rd1_node = pair_b;
            if (k_ff == '0) begin
               anc_rd0_level = '0;
            end else begin
               anc_rd0_level = k_dec;
               anc_rd1_level = k_dec;
            end
         end
         S_QRY_FINAL: begin
            dep_rd_node = anc_rd0_data;
         end
         S_DONE: begin
            done = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // Working registers.
   always_comb begin
      k_in    = k_ff;
      i_in    = i_ff;
      top_in  = top_ff;
      qa_in   = qa_ff;
      qb_in   = qb_ff;
      da_in   = da_ff;
      db_in   = db_ff;
      dsum_in = dsum_ff;
      res_in  = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in.kind     = req_beat.action;
               res_in.ancestor = '0;
               res_in.distance = '0;
               qa_in           = a_idx;
               qb_in           = b_idx;
               i_in            = NODE_W'(1);
               k_in            = LVL_W'(1);
               top_in          = top_calc;
            end
         end
         S_BLD_WR: begin
            if (i_ff == top_ff) begin
               i_in = NODE_W'(1);
               if (k_ff != LVL_LAST) begin
                  k_in = k_ff + LVL_W'(1);
               end
            end else begin
               i_in = i_ff + NODE_W'(1);
            end
         end
         S_DEP_START: begin
            qa_in = i_ff;
            da_in = DEPTH_W'(1);
            k_in  = LVL_LAST;
         end
         S_DEP_WALK: begin
            if (k_ff == '0) begin
               i_in = i_ff + NODE_W'(1);
            end else begin
               qa_in = walk_node;
               da_in = walk_depth;
               k_in  = k_dec;
            end
         end
         S_QRY_DA: begin
            da_in = dep_rd_data;
         end
         S_QRY_DB: begin
            dsum_in = DIST_W'(da_ff) + DIST_W'(dep_rd_data);
            db_in   = dep_rd_data;
            k_in    = LVL_LAST;
            // Keep the deeper node in a.
            if (da_ff < dep_rd_data) begin
               qa_in = qb_ff;
               qb_in = qa_ff;
               da_in = dep_rd_data;
               db_in = da_ff;
            end
         end
         S_LIFT_TEST: begin
            if (!lift_go) begin
               k_in = (k_ff == '0) ? LVL_LAST : k_dec;
            end
         end
         S_LIFT_ANC: begin
            qa_in = anc_rd0_data;
         end
         S_LIFT_DEP: begin
            da_in = dep_rd_data;
            k_in  = (k_ff == '0) ? LVL_LAST : k_dec;
         end
         S_PAIR_WALK: begin
            qa_in = pair_a;
            qb_in = pair_b;
            k_in  = (k_ff == '0) ? LVL_LAST : k_dec;
         end
         S_QRY_FINAL: begin
            qa_in = anc_rd0_data;
         end
         S_QRY_DC: begin
            res_in.ancestor = FIELD_W'(qa_ff);
            res_in.distance = (dsum_ff >= twice_dc) ? (dsum_ff - twice_dc) : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      top_ff  <= top_in;
      qa_ff   <= qa_in;
      qb_ff   <= qb_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      dsum_ff <= dsum_in;
      res_ff  <= res_in;
   end

   `TLD_ASSERT_IMPLY(a_anc_no_sink_write, clock, reset, anc_wr_en, anc_wr_node != '0, "ancestor write to node 0")
   `TLD_ASSERT_IMPLY(a_dep_no_sink_write, clock, reset, dep_wr_en, dep_wr_node != '0, "depth write to node 0")
   `TLD_ASSERT_IMPLY(a_build_in_range, clock, reset, anc_wr_en && (state_ff != S_IDLE), anc_wr_node <= top_ff, "build write beyond node count")
   `TLD_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, state_ff != S_IDLE, "sequencer idle after accepting a beat")
   `TLD_ASSERT_IMPLY(a_level_range, clock, reset, 1'b1, 32'(k_ff) < LOG_LEVELS, "level counter out of range")

endmodule

### design/tree_lca_distance.sv
// ----------------------------------------------------------------------------
// tree_lca_distance
// Lowest common ancestor and edge distance in a rooted tree by binary
// lifting, with the ancestor and depth tables held in on-chip memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                       Beat meaning
//  req_chan  in         action, node_a, node_b        load, build or query
//  rsp_chan  out        kind, ancestor, distance      one result per request
//  csr_chan  in         data                          node count for build
//
//  One request is worked on at a time; the next is taken while the previous
//  result still waits in the output register. A query is paced by the chain
//  of dependent reads through the ancestor and depth memories. A build fills
//  each ancestor table entry up to top, the clamped node count, through the
//  states S_BLD_RD1, S_BLD_RD2 and S_BLD_WR, then walks each node for its
//  depth. Reset is synchronous and clears control only; both tables hold
//  garbage until loaded and built, and node 0 always reads as 0.
// ----------------------------------------------------------------------------
module tree_lca_distance import tld_pkg::*; #(
   parameter int MAX_NODES  = MAX_NODES_DEF,
   parameter int LOG_LEVELS = LOG_LEVELS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   tld_req_if.sink   req_chan,
   tld_rsp_if.source rsp_chan,
   tld_csr_if.sink   csr_chan
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int LVL_W  = $clog2(LOG_LEVELS);

   logic [FIELD_W-1:0] node_count_ff, node_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_beat_ff, rsp_beat_in;

   req_beat_type       req_beat;
   rsp_beat_type       result;
   logic               rsp_free;
   logic               done;

   logic               anc_wr_en;
   logic [NODE_W-1:0]  anc_wr_node;
   logic [LVL_W-1:0]   anc_wr_level;
   logic [NODE_W-1:0]  anc_wr_data;
   logic [NODE_W-1:0]  anc_rd0_node;
   logic [LVL_W-1:0]   anc_rd0_level;
   logic [NODE_W-1:0]  anc_rd0_data;
   logic [NODE_W-1:0]  anc_rd1_node;
   logic [LVL_W-1:0]   anc_rd1_level;
   logic [NODE_W-1:0]  anc_rd1_data;
   logic               dep_wr_en;
   logic [NODE_W-1:0]  dep_wr_node;
   logic [DEPTH_W-1:0] dep_wr_data;
   logic [NODE_W-1:0]  dep_rd_node;
   logic [DEPTH_W-1:0] dep_rd_data;

   assign req_beat.action = req_chan.action;
   assign req_beat.node_a = req_chan.node_a;
   assign req_beat.node_b = req_chan.node_b;

   assign csr_chan.ready   = 1'b1;
   assign rsp_free         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind     = rsp_beat_ff.kind;
   assign rsp_chan.ancestor = rsp_beat_ff.ancestor;
   assign rsp_chan.distance = rsp_beat_ff.distance;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_chan.valid) begin
         node_count_in = csr_chan.data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   tld_seq #(
      .MAX_NODES  (MAX_NODES),
      .LOG_LEVELS (LOG_LEVELS),
      .NODE_W     (NODE_W),
      .LVL_W      (LVL_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_beat      (req_beat),
      .node_count    (node_count_ff),
      .rsp_free      (rsp_free),
      .done          (done),
      .result        (result),
      .anc_wr_en     (anc_wr_en),
      .anc_wr_node   (anc_wr_node),
      .anc_wr_level  (anc_wr_level),
      .anc_wr_data   (anc_wr_data),
      .anc_rd0_node  (anc_rd0_node),
      .anc_rd0_level (anc_rd0_level),
      .anc_rd0_data  (anc_rd0_data),
      .anc_rd1_node  (anc_rd1_node),
      .anc_rd1_level (anc_rd1_level),
      .anc_rd1_data  (anc_rd1_data),
      .dep_wr_en     (dep_wr_en),
      .dep_wr_node   (dep_wr_node),
      .dep_wr_data   (dep_wr_data),
      .dep_rd_node   (dep_rd_node),
      .dep_rd_data   (dep_rd_data)
   );

   tld_anc_mem #(
      .NODE_W (NODE_W),
      .LVL_W  (LVL_W)
   ) u_anc_mem (
      .clock     (clock),
      .wr_en     (anc_wr_en),
      .wr_node   (anc_wr_node),
      .wr_level  (anc_wr_level),
      .wr_data   (anc_wr_data),
      .rd0_node  (anc_rd0_node),
      .rd0_level (anc_rd0_level),
      .rd0_data  (anc_rd0_data),
      .rd1_node  (anc_rd1_node),
      .rd1_level (anc_rd1_level),
      .rd1_data  (anc_rd1_data)
   );

   tld_depth_mem #(
      .NODE_W (NODE_W)
   ) u_depth_mem (
      .clock   (clock),
      .wr_en   (dep_wr_en),
      .wr_node (dep_wr_node),
      .wr_data (dep_wr_data),
      .rd_node (dep_rd_node),
      .rd_data (dep_rd_data)
   );

endmodule
